FILE: hw/rtl/crfs_pkg.sv
// Shared types and constants for the CSV row field splitter.
// No dependencies; imported by every RTL module of the block.
`default_nettype none

package crfs_pkg;

    // Fixed byte codes
    localparam logic [7:0] BYTE_NL = 8'h0A;
    localparam logic [7:0] BYTE_CR = 8'h0D;

    // Saturation point of field_length
    localparam logic [23:0] LEN_MAX = 24'hFF_FFFF;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_DELIMITER    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUOTE_CHAR         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRICT_QUOTES      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FIELDS_PER_ROW = 2'd3;

    // Reset values of the registers
    localparam logic [7:0]  RST_FIELD_DELIMITER    = 8'd44;
    localparam logic [7:0]  RST_QUOTE_CHAR         = 8'd34;
    localparam logic        RST_STRICT_QUOTES      = 1'b1;
    localparam logic [10:0] RST_MAX_FIELDS_PER_ROW = 11'd1024;

    // Input request payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } in_t;

    // Result request payload
    typedef struct packed {
        logic        field_valid;
        logic [31:0] field_offset;
        logic [23:0] field_length;
        logic        length_saturated;
        logic        field_quoted;
        logic [9:0]  field_number;
        logic        row_end;
        logic        unmatched_quote;
    } out_t;

    // Decoded configuration seen by the datapath
    typedef struct packed {
        logic [7:0]  field_delimiter;
        logic [7:0]  quote_char;
        logic        strict_quotes;
        logic [10:0] field_limit;   // clamped to 1..MAX_FIELDS
    } cfg_t;

endpackage : crfs_pkg

`default_nettype wire

FILE: hw/rtl/crfs_cfg.sv
// Configuration registers of the CSV row field splitter, with field limit clamp.
// Depends on crfs_pkg.
`default_nettype none

module crfs_cfg
    import crfs_pkg::*;
#(
    parameter int MAX_FIELDS = 1024
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    localparam logic [16:0] MAX_F = 17'(MAX_FIELDS);

    logic [7:0]  delim_reg;
    logic [7:0]  quote_reg;
    logic        strict_reg;
    logic [10:0] row_cap_reg;

    logic [10:0] lim_raw;
    logic [10:0] lim;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg   <= RST_FIELD_DELIMITER;
            quote_reg   <= RST_QUOTE_CHAR;
            strict_reg  <= RST_STRICT_QUOTES;
            row_cap_reg <= RST_MAX_FIELDS_PER_ROW;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIELD_DELIMITER:    delim_reg   <= cfg_data[7:0];
                CFG_QUOTE_CHAR:         quote_reg   <= cfg_data[7:0];
                CFG_STRICT_QUOTES:      strict_reg  <= cfg_data[0];
                CFG_MAX_FIELDS_PER_ROW: row_cap_reg <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, anything above MAX_FIELDS acts as MAX_FIELDS
    always_comb
    begin
        lim_raw = (row_cap_reg == 11'd0) ? 11'd1 : row_cap_reg;
        if ({6'b0, lim_raw} > MAX_F)
            lim = MAX_F[10:0];
        else
            lim = lim_raw;
    end

    assign cfg.field_delimiter = delim_reg;
    assign cfg.quote_char      = quote_reg;
    assign cfg.strict_quotes   = strict_reg;
    assign cfg.field_limit     = lim;

endmodule : crfs_cfg

`default_nettype wire

FILE: hw/rtl/crfs_step.sv
// Per-byte tokenizer state and next-state / result logic of the splitter.
// Depends on crfs_pkg.
`default_nettype none

module crfs_step
    import crfs_pkg::*;
#(
    parameter int OFFSET_BITS = 32
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic go,       // consume item this cycle
    input  wire in_t  item,
    input  wire cfg_t cfg,
    output logic      emit,     // item produces a result
    output out_t      res
);

    localparam int OB = OFFSET_BITS;

    typedef struct packed {
        logic [OB-1:0] field_begin;
        logic [OB-1:0] content_end;
        logic [10:0]   fields_in_row;
        logic          inside_quotes;
        logic          quote_pending;
        logic          field_saw_quote;
        logic          skipping;
    } row_t;

    function automatic row_t row_start(input logic [OB-1:0] at);
        row_t r;
        r               = '0;
        r.field_begin   = at;
        r.content_end   = at;
        return r;
    endfunction

    function automatic out_t put_field(input logic [OB-1:0] fb,
                                       input logic [OB-1:0] stop,
                                       input logic          saw_q,
                                       input logic [10:0]   num);
        logic [OB-1:0]    len;
        logic [OB+23:0]   len_w;
        logic             sat;
        out_t             r;
        r                  = '0;
        len                = stop - fb;
        len_w              = {24'b0, len};
        sat                = len_w > {{OB{1'b0}}, LEN_MAX};
        r.field_valid      = 1'b1;
        r.field_offset     = 32'(fb);
        r.field_length     = sat ? LEN_MAX : len_w[23:0];
        r.length_saturated = sat;
        r.field_quoted     = saw_q;
        r.field_number     = num[9:0];
        return r;
    endfunction

    logic [OB-1:0] pos_reg, pos_next;
    row_t          row_reg, row_next;

    logic [OB-1:0] nxt;
    logic          is_nl, is_q, is_d, trim_ok, consumed;

    always_comb
    begin
        nxt      = pos_reg + {{(OB-1){1'b0}}, 1'b1};
        is_nl    = item.data_byte == BYTE_NL;
        is_q     = item.data_byte == cfg.quote_char;
        is_d     = item.data_byte == cfg.field_delimiter;
        trim_ok  = !is_nl && (item.data_byte != BYTE_CR);
        consumed = 1'b0;
        row_next = row_reg;
        emit     = 1'b0;
        res      = '0;

        if (row_reg.skipping)
        begin
            if (is_nl)
                row_next = row_start(nxt);
        end
        else
        begin
            // quote inside quotes: doubled quote stays quoted
            if (row_reg.quote_pending)
            begin
                row_next.quote_pending = 1'b0;
                if (is_q)
                begin
                    consumed = 1'b1;
                    if (trim_ok)
                        row_next.content_end = nxt;
                end
                else
                    row_next.inside_quotes = 1'b0;
            end

            if (!consumed)
            begin
                if (row_next.inside_quotes)
                begin
                    if (is_nl && !cfg.strict_quotes)
                    begin
                        res = put_field(row_reg.field_begin, pos_reg,
                                        row_reg.field_saw_quote, row_reg.fields_in_row);
                        res.row_end         = 1'b1;
                        res.unmatched_quote = 1'b1;
                        emit                = 1'b1;
                        row_next            = row_start(nxt);
                    end
                    else
                    begin
                        if (is_q)
                        begin
                            if (item.end_of_buffer)
                                row_next.inside_quotes = 1'b0;
                            else
                                row_next.quote_pending = 1'b1;
                        end
                        if (trim_ok)
                            row_next.content_end = nxt;
                    end
                end
                else if (is_q)
                begin
                    row_next.inside_quotes   = 1'b1;
                    row_next.field_saw_quote = 1'b1;
                    if (trim_ok)
                        row_next.content_end = nxt;
                end
                else if (is_nl || is_d)
                begin
                    res = put_field(row_reg.field_begin, pos_reg,
                                    row_reg.field_saw_quote, row_reg.fields_in_row);
                    emit = 1'b1;
                    if (is_nl)
                    begin
                        res.row_end = 1'b1;
                        row_next    = row_start(nxt);
                    end
                    else
                    begin
                        row_next.fields_in_row   = row_reg.fields_in_row + 11'd1;
                        row_next.field_begin     = nxt;
                        row_next.content_end     = nxt;
                        row_next.field_saw_quote = 1'b0;
                        if (row_next.fields_in_row >= cfg.field_limit)
                        begin
                            res.row_end       = 1'b1;
                            row_next.skipping = 1'b1;
                        end
                        if (item.end_of_buffer)
                            res.row_end = 1'b1;
                    end
                end
                else if (trim_ok)
                    row_next.content_end = nxt;
            end
        end

        // trailing field at end of buffer, CR/LF already trimmed off
        if (item.end_of_buffer && !emit && !row_reg.skipping)
        begin
            if (row_next.content_end != row_next.field_begin)
            begin
                res = put_field(row_next.field_begin, row_next.content_end,
                                row_next.field_saw_quote, row_next.fields_in_row);
                res.row_end         = 1'b1;
                res.unmatched_quote = row_next.inside_quotes;
                emit                = 1'b1;
            end
            else if ((row_next.fields_in_row != 11'd0) || row_next.inside_quotes)
            begin
                res                 = '0;
                res.row_end         = 1'b1;
                res.unmatched_quote = row_next.inside_quotes;
                emit                = 1'b1;
            end
        end

        if (item.end_of_buffer)
        begin
            pos_next = '0;
            row_next = row_start('0);
        end
        else
            pos_next = nxt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            row_reg <= '0;
        end
        else if (go)
        begin
            pos_reg <= pos_next;
            row_reg <= row_next;
        end
    end

endmodule : crfs_step

`default_nettype wire

FILE: hw/rtl/csv_row_field_splitter.sv
// Top level of the CSV row field splitter: input register, tokenizer, result register.
// Depends on crfs_pkg, crfs_cfg and crfs_step.
`default_nettype none

//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------
//  in      | input     | in_valid / in_ready | in_t: data_byte, end_of_buffer
//  out     | output    | out_valid/out_ready | out_t: one field record or row end
//  cfg     | input     | cfg_we (no wait)    | cfg_index, cfg_data
//
// One input request per cycle while results are taken. The byte is captured in
// the input register; the tokenizer then updates its row state and loads the
// result register once that is free. A byte yields zero or one result.
// Reset (rst_n, async, active low) clears positions, row state and valid bits;
// registers return to delimiter ',', quote '"', strict mode, 1024 fields per row.
// A stalled result holds the result register; the input register keeps taking
// a new request while the result register drains, so stalls cost no bubble.

module csv_row_field_splitter
    import crfs_pkg::*;
#(
    parameter int MAX_FIELDS  = 1024,
    parameter int OFFSET_BITS = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire in_t                   in_data,

    output logic                       out_valid,
    input  wire logic                  out_ready,
    output out_t                       out_data,

    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg;

    logic  in_vld_reg;
    in_t   in_hold_reg;
    logic  out_vld_reg;
    out_t  out_data_reg;

    logic  adv;        // tokenizer consumes the held byte
    logic  emit;
    out_t  res;

    crfs_cfg #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Held byte moves on when the result register is empty or being taken.
    assign adv      = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_valid && in_ready)
            in_vld_reg <= 1'b1;
        else if (adv)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_hold_reg <= in_data;
    end

    crfs_step #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (adv),
        .item  (in_hold_reg),
        .cfg   (cfg),
        .emit  (emit),
        .res   (res)
    );

    // Result register; bytes without a result leave it alone.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv && emit)
            out_vld_reg <= 1'b1;
        else if (out_ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv && emit)
            out_data_reg <= res;
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

    // A bare record (no field) only ever closes a row.
    a_bare_is_row_end : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.field_valid |-> out_data.row_end)
        else $error("bare result without row_end");

    // Unmatched quote is only reported on a row end.
    a_unmatched_on_row_end : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.unmatched_quote |-> out_data.row_end)
        else $error("unmatched_quote without row_end");

    // Saturation flag goes with a clipped length.
    a_sat_length : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.length_saturated |-> out_data.field_length == LEN_MAX)
        else $error("saturated length not clipped");

    // A held byte behind a stalled result is kept, not dropped.
    a_hold_in_reg : assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && out_vld_reg && !out_ready |=> in_vld_reg)
        else $error("input register lost a byte during stall");

endmodule : csv_row_field_splitter

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for csv_row_field_splitter: a short directed table, then random CSV
// buffers under several settings, checked against typed records or an in-bench tokenizer.
// Depends on crfs_pkg and the RTL of the block; nothing else.
`timescale 1ns / 1ps

module tb_top
    import crfs_pkg::*;
();

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int FIELD_CAP       = 1024;  // MAX_FIELDS of the instance
    localparam int DRAIN_CYCLES    = 4;     // covers the input and result registers, plus margin

    typedef enum logic [0:0] { ROW_BYTE, ROW_SETTING } drill_kind_t;

    // One line of the directed table: a byte request, or a register change.
    typedef struct packed {
        drill_kind_t kind;
        in_t         item;
        logic        typed;     // known record typed in below
        out_t        known;
        logic        strict_q;
        logic [10:0] limit;
    } drill_row_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_t                   in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_t                  out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_FIELD_DELIMITER;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    always #10 clk = ~clk;

    csv_row_field_splitter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Tokenizer mirror: registers and row state as the block should hold them
    // ------------------------------------------------------------------
    logic [7:0]  cfg_delim  = RST_FIELD_DELIMITER;
    logic [7:0]  cfg_quote  = RST_QUOTE_CHAR;
    logic        cfg_strict = RST_STRICT_QUOTES;
    logic [10:0] cfg_limit  = RST_MAX_FIELDS_PER_ROW;

    logic [31:0] tok_pos     = '0;
    logic [31:0] tok_begin   = '0;
    logic [31:0] tok_cend    = '0;   // just past last non-CR/LF byte of the field
    logic [10:0] tok_nfields = '0;
    logic        tok_inq     = 1'b0;
    logic        tok_qpend   = 1'b0; // quote inside quotes, doubled or closing?
    logic        tok_sawq    = 1'b0;
    logic        tok_skip    = 1'b0; // field limit hit, dropping bytes to newline

    out_t        pending_fields [$];
    drill_row_t  drill [$];

    int          mismatches   = 0;
    int          quiet_cycles = 0;
    int          sink_hold    = 0;
    bit          src_gaps     = 1'b0;
    bit          sink_stalls  = 1'b0;
    bit          calm         = 1'b0;
    out_t        seen_rec;
    out_t        want_rec;

    function automatic void new_row(input logic [31:0] at);
        tok_begin   = at;
        tok_cend    = at;
        tok_nfields = '0;
        tok_inq     = 1'b0;
        tok_qpend   = 1'b0;
        tok_sawq    = 1'b0;
        tok_skip    = 1'b0;
    endfunction

    function automatic out_t field_record(input logic [31:0] stop);
        logic [31:0] span;
        out_t        r;
        span = stop - tok_begin;
        r = '0;
        r.field_valid  = 1'b1;
        r.field_offset = tok_begin;
        if (span > {8'd0, LEN_MAX})
        begin
            r.field_length     = LEN_MAX;
            r.length_saturated = 1'b1;
        end
        else
        begin
            r.field_length = span[23:0];
        end
        r.field_quoted = tok_sawq;
        r.field_number = tok_nfields[9:0];
        return r;
    endfunction

    // Advance the mirror by one byte; returns 1 when the byte yields a record.
    function automatic logic split_byte(input in_t item, output out_t rec);
        logic [7:0]  b;
        logic [31:0] here;
        logic [31:0] after;
        logic [10:0] row_limit;
        logic        eob;
        logic        was_skip;
        logic        trim_ok;
        logic        taken;
        logic        got;
        b         = item.data_byte;
        eob       = item.end_of_buffer;
        here      = tok_pos;
        after     = tok_pos + 32'd1;
        was_skip  = tok_skip;
        trim_ok   = (b != BYTE_CR) && (b != BYTE_NL);
        taken     = 1'b0;
        got       = 1'b0;
        rec       = '0;
        row_limit = (cfg_limit == 11'd0) ? 11'd1 :
                    (cfg_limit > 11'(FIELD_CAP)) ? 11'(FIELD_CAP) : cfg_limit;

        if (was_skip)
        begin
            if (b == BYTE_NL)
                new_row(after);
        end
        else
        begin
            // byte after a quote inside quotes: doubled quote or close
            if (tok_qpend)
            begin
                tok_qpend = 1'b0;
                if (b == cfg_quote)
                begin
                    taken = 1'b1;
                    if (trim_ok)
                        tok_cend = after;
                end
                else
                begin
                    tok_inq = 1'b0;
                end
            end
            if (!taken)
            begin
                if (tok_inq)
                begin
                    if (b == BYTE_NL && !cfg_strict)
                    begin
                        rec = field_record(here);
                        rec.row_end         = 1'b1;
                        rec.unmatched_quote = 1'b1;
                        got = 1'b1;
                        new_row(after);
                    end
                    else
                    begin
                        if (b == cfg_quote)
                        begin
                            if (eob)
                                tok_inq = 1'b0;
                            else
                                tok_qpend = 1'b1;
                        end
                        if (trim_ok)
                            tok_cend = after;
                    end
                end
                else if (b == cfg_quote)
                begin
                    tok_inq  = 1'b1;
                    tok_sawq = 1'b1;
                    if (trim_ok)
                        tok_cend = after;
                end
                else if (b == BYTE_NL || b == cfg_delim)
                begin
                    rec = field_record(here);
                    got = 1'b1;
                    if (b == BYTE_NL)
                    begin
                        rec.row_end = 1'b1;
                        new_row(after);
                    end
                    else
                    begin
                        tok_nfields = tok_nfields + 11'd1;
                        tok_begin   = after;
                        tok_cend    = after;
                        tok_sawq    = 1'b0;
                        if (tok_nfields >= row_limit)
                        begin
                            rec.row_end = 1'b1;
                            tok_skip    = 1'b1;
                        end
                        if (eob)
                            rec.row_end = 1'b1;
                    end
                end
                else if (trim_ok)
                begin
                    tok_cend = after;
                end
            end
        end

        // trailing field of the buffer, or a bare row end
        if (eob && !got && !was_skip)
        begin
            if (tok_cend != tok_begin)
            begin
                rec = field_record(tok_cend);
                rec.row_end         = 1'b1;
                rec.unmatched_quote = tok_inq;
                got = 1'b1;
            end
            else if (tok_nfields != 11'd0 || tok_inq)
            begin
                rec = '0;
                rec.row_end         = 1'b1;
                rec.unmatched_quote = tok_inq;
                got = 1'b1;
            end
        end

        if (eob)
        begin
            tok_pos = '0;
            new_row('0);
        end
        else
        begin
            tok_pos = after;
        end
        return got;
    endfunction

    // ------------------------------------------------------------------
    // Directed table helpers
    // ------------------------------------------------------------------
    function automatic in_t mk_byte(input logic [7:0] b, input logic eob);
        in_t it;
        it.data_byte     = b;
        it.end_of_buffer = eob;
        return it;
    endfunction

    function automatic out_t field_at(input logic valid, input logic [31:0] offset,
                                      input logic [23:0] length, input logic quoted,
                                      input logic [9:0] number, input logic last,
                                      input logic open_quote);
        out_t r;
        r                  = '0;
        r.field_valid      = valid;
        r.field_offset     = offset;
        r.field_length     = length;
        r.field_quoted     = quoted;
        r.field_number     = number;
        r.row_end          = last;
        r.unmatched_quote  = open_quote;
        return r;
    endfunction

    function automatic drill_row_t step_byte(input logic [7:0] b, input logic eob);
        drill_row_t d;
        d      = '0;
        d.kind = ROW_BYTE;
        d.item = mk_byte(b, eob);
        return d;
    endfunction

    function automatic drill_row_t step_known(input logic [7:0] b, input logic eob,
                                              input out_t known);
        drill_row_t d;
        d       = step_byte(b, eob);
        d.typed = 1'b1;
        d.known = known;
        return d;
    endfunction

    function automatic drill_row_t step_setting(input logic strict_q,
                                                input logic [10:0] limit);
        drill_row_t d;
        d          = '0;
        d.kind     = ROW_SETTING;
        d.strict_q = strict_q;
        d.limit    = limit;
        return d;
    endfunction

    // ------------------------------------------------------------------
    // Reporting and result checking
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] wanted);
        if (mismatches < 100)
            $display("mismatch at %0d ns: %s got 0x%0h wanted 0x%0h",
                     $time, what, got, wanted);
        mismatches++;
    endtask

    // Output side: random stall bursts on out_ready.
    always @(posedge clk)
    begin
        if (sink_hold > 0)
            sink_hold--;
        else if (sink_stalls && $urandom_range(0, 11) == 0)
            sink_hold = $urandom_range(1, 15);
        out_ready <= (sink_hold == 0);
    end

    // Every accepted result request is compared with the oldest expectation.
    // The watchdog counts cycles with no request moving on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                seen_rec = out_data;
                if (pending_fields.size() == 0)
                begin
                    flag_mismatch("result with none expected", seen_rec.field_offset, '0);
                end
                else
                begin
                    want_rec = pending_fields.pop_front();
                    if (seen_rec.field_valid !== want_rec.field_valid)
                        flag_mismatch("field_valid", 32'(seen_rec.field_valid),
                                      32'(want_rec.field_valid));
                    if (seen_rec.field_offset !== want_rec.field_offset)
                        flag_mismatch("field_offset", seen_rec.field_offset,
                                      want_rec.field_offset);
                    if (seen_rec.field_length !== want_rec.field_length)
                        flag_mismatch("field_length", 32'(seen_rec.field_length),
                                      32'(want_rec.field_length));
                    if (seen_rec.length_saturated !== want_rec.length_saturated)
                        flag_mismatch("length_saturated", 32'(seen_rec.length_saturated),
                                      32'(want_rec.length_saturated));
                    if (seen_rec.field_quoted !== want_rec.field_quoted)
                        flag_mismatch("field_quoted", 32'(seen_rec.field_quoted),
                                      32'(want_rec.field_quoted));
                    if (seen_rec.field_number !== want_rec.field_number)
                        flag_mismatch("field_number", 32'(seen_rec.field_number),
                                      32'(want_rec.field_number));
                    if (seen_rec.row_end !== want_rec.row_end)
                        flag_mismatch("row_end", 32'(seen_rec.row_end),
                                      32'(want_rec.row_end));
                    if (seen_rec.unmatched_quote !== want_rec.unmatched_quote)
                        flag_mismatch("unmatched_quote", 32'(seen_rec.unmatched_quote),
                                      32'(want_rec.unmatched_quote));
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_CYCLES)
            begin
                $display("timeout: no request moved for %0d cycles", WATCHDOG_CYCLES);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one byte request, when gaps are on sometimes with a random idle burst
    // ahead of it; the mirror advances at the edge where the request is taken.
    task automatic push_byte(input in_t item, input logic typed, input out_t known);
        out_t rec;
        logic got;
        if (src_gaps && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        got = split_byte(item, rec);
        if (typed)
            pending_fields.push_back(known);
        else if (got)
            pending_fields.push_back(rec);
    endtask

    // Stop sending, let every expected record arrive, then give the pipeline
    // time to finish bytes that produce nothing.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_fields.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Only called while the block is idle.
    task automatic apply_setting(input logic [7:0] delim, input logic [7:0] quote,
                                 input logic strict_q, input logic [10:0] limit);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FIELD_DELIMITER;
        cfg_data  <= CFG_DATA_W'(delim);
        @(posedge clk);
        cfg_index <= CFG_QUOTE_CHAR;
        cfg_data  <= CFG_DATA_W'(quote);
        @(posedge clk);
        cfg_index <= CFG_STRICT_QUOTES;
        cfg_data  <= CFG_DATA_W'(strict_q);
        @(posedge clk);
        cfg_index <= CFG_MAX_FIELDS_PER_ROW;
        cfg_data  <= limit;
        @(posedge clk);
        cfg_we     <= 1'b0;
        cfg_delim  = delim;
        cfg_quote  = quote;
        cfg_strict = strict_q;
        cfg_limit  = limit;
    endtask

    // Mostly letters, sometimes any byte at all.
    function automatic logic [7:0] filler_byte();
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    // Random buffers: mostly well-formed rows (quoted fields, doubled quotes,
    // embedded delimiters/newlines, CRLF endings), some raw noise.
    task automatic play_csv(input int budget);
        in_t chunk [$];
        int  rows;
        int  nf;
        int  len;
        while (budget > 0)
        begin
            chunk.delete();
            if (!calm)
            begin
                src_gaps    = ($urandom_range(0, 3) != 0);
                sink_stalls = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 12))
                    chunk.push_back(mk_byte(8'($urandom_range(0, 255)),
                                            $urandom_range(0, 7) == 0));
            end
            else
            begin
                rows = $urandom_range(1, 4);
                for (int r = 0; r < rows; r++)
                begin
                    nf = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 12)
                                                     : $urandom_range(1, 4);
                    for (int f = 0; f < nf; f++)
                    begin
                        if (f != 0)
                            chunk.push_back(mk_byte(cfg_delim, 1'b0));
                        len = $urandom_range(0, 5);
                        if ($urandom_range(0, 2) == 0)
                        begin
                            chunk.push_back(mk_byte(cfg_quote, 1'b0));
                            repeat (len)
                            begin
                                case ($urandom_range(0, 9))
                                    0:
                                    begin
                                        chunk.push_back(mk_byte(cfg_quote, 1'b0));
                                        chunk.push_back(mk_byte(cfg_quote, 1'b0));
                                    end
                                    1: chunk.push_back(mk_byte(cfg_delim, 1'b0));
                                    2: chunk.push_back(mk_byte(BYTE_NL, 1'b0));
                                    default: chunk.push_back(mk_byte(filler_byte(), 1'b0));
                                endcase
                            end
                            // now and then the closing quote is missing
                            if ($urandom_range(0, 7) != 0)
                                chunk.push_back(mk_byte(cfg_quote, 1'b0));
                        end
                        else
                        begin
                            repeat (len)
                                chunk.push_back(mk_byte(filler_byte(), 1'b0));
                        end
                    end
                    case ($urandom_range(0, 3))
                        0:
                        begin
                            chunk.push_back(mk_byte(BYTE_CR, 1'b0));
                            chunk.push_back(mk_byte(BYTE_NL, 1'b0));
                        end
                        1: if (r != rows - 1)
                               chunk.push_back(mk_byte(BYTE_NL, 1'b0));
                        default: chunk.push_back(mk_byte(BYTE_NL, 1'b0));
                    endcase
                end
                if (chunk.size() == 0)
                    chunk.push_back(mk_byte(filler_byte(), 1'b0));
                chunk[chunk.size() - 1].end_of_buffer = 1'b1;
            end
            foreach (chunk[i])
            begin
                push_byte(chunk[i], 1'b0, '0);
                budget--;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        // Directed table, registers at reset values (',' and '"', strict, 1024).
        drill.push_back(step_byte(8'h00, 1'b0));
        drill.push_back(step_byte(8'hFF, 1'b0));
        drill.push_back(step_known(RST_FIELD_DELIMITER, 1'b0,
                                   field_at(1'b1, 32'd0, 24'd2, 1'b0, 10'd0, 1'b0, 1'b0)));
        // quoted field holding a delimiter and a doubled quote, closed by newline
        drill.push_back(step_byte(RST_QUOTE_CHAR, 1'b0));
        drill.push_back(step_byte(RST_FIELD_DELIMITER, 1'b0));
        drill.push_back(step_byte(RST_QUOTE_CHAR, 1'b0));
        drill.push_back(step_byte(RST_QUOTE_CHAR, 1'b0));
        drill.push_back(step_byte(RST_QUOTE_CHAR, 1'b0));
        drill.push_back(step_byte(BYTE_NL, 1'b0));
        // delimiter as the final byte: the field it closes ends the row
        drill.push_back(step_known(RST_FIELD_DELIMITER, 1'b1,
                                   field_at(1'b1, 32'd9, 24'd0, 1'b0, 10'd0, 1'b1, 1'b0)));
        // trailing CR trimmed from the last field
        drill.push_back(step_byte(8'h78, 1'b0));
        drill.push_back(step_known(BYTE_CR, 1'b1,
                                   field_at(1'b1, 32'd0, 24'd1, 1'b0, 10'd0, 1'b1, 1'b0)));
        // empty trailing field after a delimiter: bare row end
        drill.push_back(step_byte(RST_FIELD_DELIMITER, 1'b0));
        drill.push_back(step_known(BYTE_CR, 1'b1,
                                   field_at(1'b0, 32'd0, 24'd0, 1'b0, 10'd0, 1'b1, 1'b0)));
        // buffer ends inside quotes
        drill.push_back(step_byte(RST_QUOTE_CHAR, 1'b0));
        drill.push_back(step_known(8'h71, 1'b1,
                                   field_at(1'b1, 32'd0, 24'd2, 1'b1, 10'd0, 1'b1, 1'b1)));
        // loose quotes, two fields per row
        drill.push_back(step_setting(1'b0, 11'd2));
        drill.push_back(step_byte(RST_QUOTE_CHAR, 1'b0));
        drill.push_back(step_known(BYTE_NL, 1'b0,
                                   field_at(1'b1, 32'd0, 24'd1, 1'b1, 10'd0, 1'b1, 1'b1)));
        drill.push_back(step_byte(RST_FIELD_DELIMITER, 1'b0));
        drill.push_back(step_byte(RST_FIELD_DELIMITER, 1'b0));  // hits the limit
        drill.push_back(step_byte(BYTE_NL, 1'b0));              // skipped, new row
        drill.push_back(step_byte(RST_QUOTE_CHAR, 1'b1));
        // quote on the final byte while quoted closes the quotes
        drill.push_back(step_byte(RST_QUOTE_CHAR, 1'b0));
        drill.push_back(step_known(RST_QUOTE_CHAR, 1'b1,
                                   field_at(1'b1, 32'd0, 24'd2, 1'b1, 10'd0, 1'b1, 1'b0)));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        foreach (drill[i])
        begin
            if (drill[i].kind == ROW_SETTING)
            begin
                settle();
                apply_setting(cfg_delim, cfg_quote, drill[i].strict_q, drill[i].limit);
            end
            else
            begin
                push_byte(drill[i].item, drill[i].typed, drill[i].known);
            end
        end

        // Defaults, with a full drain of the results half way through.
        settle();
        apply_setting(RST_FIELD_DELIMITER, RST_QUOTE_CHAR, 1'b1, RST_MAX_FIELDS_PER_ROW);
        play_csv(70);
        settle();
        play_csv(70);

        // Byte-code extremes; a limit of zero behaves as one.
        settle();
        apply_setting(8'h00, 8'hFF, 1'b0, 11'd0);
        play_csv(70);
        settle();
        apply_setting(8'hFF, 8'h00, 1'b1, 11'd1);
        play_csv(70);
        settle();
        apply_setting(8'h09, 8'h27, 1'b0, 11'd3);
        play_csv(70);

        // Shared codes: quote equals delimiter, newline as quote, newline as delimiter.
        settle();
        apply_setting(8'h3B, 8'h3B, 1'b0, 11'd2);
        play_csv(70);
        settle();
        apply_setting(8'h2C, BYTE_NL, 1'b0, 11'd5);
        play_csv(70);
        settle();
        apply_setting(BYTE_NL, 8'h22, 1'b1, 11'd4);
        play_csv(70);

        // Limit above the field cap clamps to the cap; rows here stay well below it,
        // so nothing is cut short.
        settle();
        apply_setting(8'h7C, 8'h22, 1'b1, 11'd2047);
        play_csv(70);

        // Last stretch at full rate on both sides.
        settle();
        calm        = 1'b1;
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        apply_setting(RST_FIELD_DELIMITER, RST_QUOTE_CHAR, 1'b1, RST_MAX_FIELDS_PER_ROW);
        play_csv(70);
        settle();

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/crfs_pkg.sv
hw/rtl/crfs_cfg.sv
hw/rtl/crfs_step.sv
hw/rtl/csv_row_field_splitter.sv
bench/tb_top.sv
